FILE: rtl/sbpf_pkg.sv
`default_nettype none

package sbpf_pkg;

	localparam int NUM_BINS  = 75;
	localparam int BIN_W     = 7;
	localparam int LEVEL_W   = 8;
	localparam int SEL_W     = 3;
	localparam int BAR_W     = 16;
	localparam int SPEED_W   = 24;
	localparam int GROW_W    = 9;
	localparam int CFG_IDX_W = 2;
	// bin index into the store, and a bin width that can hold NUM_BINS itself
	localparam int IDX_W     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int BIN_EXT_W = 9;

	localparam logic [SPEED_W-1:0] SPEED_RESTART = 24'd655;
	localparam logic [SPEED_W-1:0] SPEED_MAX     = 24'hFFFFFF;

	localparam logic [CFG_IDX_W-1:0] REG_BAR_SEL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_SEL = 2'd1;

	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic [BAR_W-1:0]   peak;
		logic [BAR_W-1:0]   bar;
	} bin_state_t;

	// bar fall step, Q8.8; selectors above 4 act as 4
	function automatic logic [BAR_W-1:0] bar_step(input logic [SEL_W-1:0] sel);
		logic [BAR_W-1:0] r;
		case (sel)
			3'd0:    r = 16'd87;
			3'd1:    r = 16'd128;
			3'd2:    r = 16'd256;
			3'd3:    r = 16'd333;
			default: r = 16'd410;
		endcase
		return r;
	endfunction

	// peak speed growth factor, Q1.8
	function automatic logic [GROW_W-1:0] growth(input logic [SEL_W-1:0] sel);
		logic [GROW_W-1:0] r;
		case (sel)
			3'd0:    r = 9'd307;
			3'd1:    r = 9'd333;
			3'd2:    r = 9'd358;
			3'd3:    r = 9'd384;
			default: r = 9'd410;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/spectrum_bar_peak_falloff_unit.sv
`default_nettype none
// channel | dir | fields (tdata/tuser from bit 0 up)
// s_*     | in  | tdata: bin_index[6:0], sample_level[14:7], zero pad [15]
// m_*     | out | tdata: bin_echo[6:0], bar_level[14:7], peak_level[22:15], pad [23]
// cfg_*   | in  | cfg_index 0 = bar falloff select, 1 = peak falloff select; data 3 bits
//
// One item per cycle sustained while the output is not stalled, any mix of bins,
// including the same bin back to back. Store read at accept, update and write-back
// in stage 1, result register after that. The feedback loop is update logic plus
// the write-forward mux around the one-port-read, one-port-write store.
// Reset clears selectors and per-bin valid flags at once; no clearing pass.
// A stalled output holds the whole pipe; s_tready follows the result register.

module spectrum_bar_peak_falloff_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // bin_index, sample_level
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // bin_echo, bar_level, peak_level
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [sbpf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sbpf_pkg::SEL_W-1:0]     cfg_data
);
	import sbpf_pkg::*;

	logic [SEL_W-1:0]     bar_sel_q;
	logic [SEL_W-1:0]     peak_sel_q;

	logic                 adv;
	logic                 acc;
	logic [BIN_W-1:0]     in_bin;
	logic [LEVEL_W-1:0]   in_lvl;
	logic [BIN_EXT_W-1:0] in_bin_ext;
	logic                 in_range;

	logic                 v_s1;
	logic                 inr_s1;
	logic [BIN_W-1:0]     bin_s1;
	logic [LEVEL_W-1:0]   lvl_s1;
	logic [IDX_W-1:0]     idx_s1;

	bin_state_t           cur;
	bin_state_t           nxt;
	logic                 wr_en;

	logic                 m_tvalid_q;
	logic [BIN_W-1:0]     out_bin_q;
	logic [LEVEL_W-1:0]   out_bar_q;
	logic [LEVEL_W-1:0]   out_peak_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_sel_q  <= '0;
			peak_sel_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BAR_SEL:  bar_sel_q  <= cfg_data;
				REG_PEAK_SEL: peak_sel_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipe moves when the result register is free or being drained
	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv;
	assign acc      = s_tvalid && adv;

	assign in_bin     = s_tdata[BIN_W-1:0];
	assign in_lvl     = s_tdata[BIN_W+LEVEL_W-1:BIN_W];
	assign in_bin_ext = BIN_EXT_W'(in_bin);
	assign in_range   = in_bin_ext < BIN_EXT_W'(NUM_BINS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			bin_s1 <= in_bin;
			lvl_s1 <= in_lvl;
			inr_s1 <= in_range;
			idx_s1 <= in_bin_ext[IDX_W-1:0];
		end
	end

	sbpf_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc && in_range),
		.rd_idx  (in_bin_ext[IDX_W-1:0]),
		.wr_en   (wr_en),
		.wr_idx  (idx_s1),
		.wr_data (nxt),
		.rd_data (cur)
	);

	sbpf_update u_update (
		.cur      (cur),
		.level    (lvl_s1),
		.bar_sel  (bar_sel_q),
		.peak_sel (peak_sel_q),
		.nxt      (nxt)
	);

	// out-of-range bins leave the store alone and report zero levels
	assign wr_en = adv && v_s1 && inr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			out_bin_q  <= bin_s1;
			out_bar_q  <= inr_s1 ? nxt.bar[BAR_W-1:8]  : '0;
			out_peak_q <= inr_s1 ? nxt.peak[BAR_W-1:8] : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_peak_q, out_bar_q, out_bin_q};

`ifndef SYNTHESIS
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (BIN_EXT_W'(out_bin_q) >= BIN_EXT_W'(NUM_BINS))
			|-> (out_bar_q == '0 && out_peak_q == '0))
		else $error("out-of-range bin reported nonzero levels");

	a_peak_ge_bar: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> out_peak_q >= out_bar_q)
		else $error("peak below bar");

	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(v_s1))
		else $error("result without item in stage 1");

	a_wr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> (v_s1 && $stable(bin_s1) && $stable(lvl_s1)))
		else $error("stage 1 item lost during stall");
`endif

endmodule

`default_nettype wire

FILE: rtl/sbpf_store.sv
`default_nettype none

module sbpf_store (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   rd_en,
	input  wire logic [sbpf_pkg::IDX_W-1:0] rd_idx,
	input  wire logic                   wr_en,
	input  wire logic [sbpf_pkg::IDX_W-1:0] wr_idx,
	input  wire sbpf_pkg::bin_state_t   wr_data,
	output sbpf_pkg::bin_state_t        rd_data
);
	import sbpf_pkg::*;

	bin_state_t           mem [NUM_BINS];
	logic [NUM_BINS-1:0]  vld_q;

	bin_state_t           rd_data_s1;
	logic                 vld_s1;
	logic [IDX_W-1:0]     rd_idx_s1;

	bin_state_t           fwd_data_q;
	logic [IDX_W-1:0]     fwd_idx_q;
	logic                 fwd_vld_q;

	// read-before-write: a read and a write at the same edge see old data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_idx];
			rd_idx_s1  <= rd_idx;
		end
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			vld_s1    <= 1'b0;
			fwd_vld_q <= 1'b0;
		end else begin
			if (rd_en) begin
				vld_s1 <= vld_q[rd_idx];
			end
			if (wr_en) begin
				vld_q[wr_idx] <= 1'b1;
				fwd_vld_q     <= 1'b1;
			end
		end
	end

	// last write, for a read issued at the edge where it landed
	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_data_q <= wr_data;
			fwd_idx_q  <= wr_idx;
		end
	end

	always_comb begin
		if (fwd_vld_q && fwd_idx_q == rd_idx_s1) begin
			rd_data = fwd_data_q;
		end else if (vld_s1) begin
			rd_data = rd_data_s1;
		end else begin
			rd_data = '0;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sbpf_update.sv
`default_nettype none

module sbpf_update (
	input  wire sbpf_pkg::bin_state_t        cur,
	input  wire logic [sbpf_pkg::LEVEL_W-1:0] level,
	input  wire logic [sbpf_pkg::SEL_W-1:0]   bar_sel,
	input  wire logic [sbpf_pkg::SEL_W-1:0]   peak_sel,
	output sbpf_pkg::bin_state_t             nxt
);
	import sbpf_pkg::*;

	logic [BAR_W-1:0]           lvl16;
	logic [BAR_W-1:0]           step;
	logic [BAR_W-1:0]           new_bar;
	logic [SPEED_W-1:0]         wide;
	logic [BAR_W-1:0]           dec_peak;
	logic [BAR_W-1:0]           flr_peak;
	logic [SPEED_W+GROW_W-1:0]  prod;
	logic [SPEED_W:0]           grown;
	logic [SPEED_W-1:0]         sat_speed;
	logic                       rise;
	logic [SPEED_W-1:0]         diff;

	always_comb begin
		lvl16   = {level, 8'h00};
		step    = bar_step(bar_sel);
		rise    = lvl16 > cur.bar;
		if (rise) begin
			new_bar = lvl16;
		end else if (cur.bar > step) begin
			new_bar = cur.bar - step;
		end else begin
			new_bar = '0;
		end

		// peak decay in Q8.16, truncated back to Q8.8, floored at the bar
		wide = {cur.peak, 8'h00};
		diff = wide - cur.speed;
		dec_peak = (wide > cur.speed) ? diff[SPEED_W-1:8] : '0;
		flr_peak = (dec_peak < new_bar) ? new_bar : dec_peak;

		prod      = (SPEED_W+GROW_W)'(cur.speed) * (SPEED_W+GROW_W)'(growth(peak_sel));
		grown     = prod[SPEED_W+GROW_W-1:8];
		sat_speed = grown[SPEED_W] ? SPEED_MAX : grown[SPEED_W-1:0];

		nxt.bar = new_bar;
		if (rise && new_bar > cur.peak) begin
			nxt.peak  = new_bar;
			nxt.speed = SPEED_RESTART;
		end else if (cur.peak == '0) begin
			nxt.peak  = cur.peak;
			nxt.speed = cur.speed;
		end else begin
			nxt.peak  = flr_peak;
			nxt.speed = sat_speed;
		end
	end

endmodule

`default_nettype wire

FILE: dv/spectrum_bar_peak_falloff_unit_tb.sv
`default_nettype none

module spectrum_bar_peak_falloff_unit_tb;

	import sbpf_pkg::*;

	localparam int BINS = sbpf_pkg::NUM_BINS;

	// register indexes the block does not decode; a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam logic [23:0] SPEED_ON_CAPTURE = 24'd655;      // 0.01 in Q8.16
	localparam logic [23:0] SPEED_CEILING    = 24'hFFFFFF;

	// one predicted result item
	typedef struct packed {
		logic [6:0] bin;
		logic [7:0] bar;
		logic [7:0] peak;
	} meter_reading_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;          // bin_index[6:0], sample_level[14:7], pad[15]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;               // bin_echo[6:0], bar_level[14:7], peak_level[22:15]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SEL_W-1:0]     cfg_data = '0;

	// mirror of the block's per-bin meter state and its selectors
	logic [15:0] bar_mirror   [BINS];
	logic [15:0] peak_mirror  [BINS];
	logic [23:0] speed_mirror [BINS];
	logic [2:0]  bar_sel;
	logic [2:0]  peak_sel;

	meter_reading_t readings_q[$];

	// when set, neither side idles
	bit stall_free = 1'b0;

	int mismatches    = 0;
	int items_sent    = 0;
	int results_seen  = 0;
	int reg_writes    = 0;
	int far_bins      = 0;
	int captures      = 0;
	int saturations   = 0;

	spectrum_bar_peak_falloff_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#5000000;
		$display("FAIL spectrum_bar_peak_falloff_unit");
		$finish;
	end

	// output side back-pressure: ~6% stall cycles unless in the stall-free stretch
	always @(posedge clk) begin
		m_tready <= stall_free ? 1'b1 : ($urandom_range(0, 99) >= 6);
	end

	// ---------------------------------------------------------------- predictor

	// bar fall step, Q8.8; selectors past 4 saturate
	function automatic logic [15:0] fall_step_q88(input logic [2:0] sel);
		case (sel)
			3'd0:    return 16'd87;
			3'd1:    return 16'd128;
			3'd2:    return 16'd256;
			3'd3:    return 16'd333;
			default: return 16'd410;
		endcase
	endfunction

	// peak speed gain, Q1.8
	function automatic logic [8:0] speed_gain_q18(input logic [2:0] sel);
		case (sel)
			3'd0:    return 9'd307;
			3'd1:    return 9'd333;
			3'd2:    return 9'd358;
			3'd3:    return 9'd384;
			default: return 9'd410;
		endcase
	endfunction

	// peak falls by its speed (Q8.16), floored at zero and at the bar; speed then grows
	function automatic void sink_peak(input int b);
		logic [15:0] pk;
		logic [23:0] sp;
		logic [23:0] wide;
		logic [15:0] fell;
		logic [33:0] grown;
		pk = peak_mirror[b];
		sp = speed_mirror[b];
		if (pk == 16'd0)
			return;
		wide = {pk, 8'd0};
		fell = (wide > sp) ? 16'((wide - sp) >> 8) : 16'd0;
		grown = (34'(sp) * 34'(speed_gain_q18(peak_sel))) >> 8;
		if (grown > 34'(SPEED_CEILING)) begin
			speed_mirror[b] = SPEED_CEILING;
			saturations++;
		end else begin
			speed_mirror[b] = grown[23:0];
		end
		if (fell < bar_mirror[b])
			fell = bar_mirror[b];
		peak_mirror[b] = fell;
	endfunction

	// apply one sample to the mirror and return the reading the block must produce
	function automatic meter_reading_t meter_update(input logic [6:0] bin, input logic [7:0] lvl);
		meter_reading_t r;
		logic [15:0] bar;
		logic [15:0] st;
		int b;
		b = int'(bin);
		r.bin = bin;
		if (b >= BINS) begin
			// out-of-range bin: echoed with zero levels, store untouched
			r.bar = 8'd0;
			r.peak = 8'd0;
			far_bins++;
			return r;
		end
		bar = bar_mirror[b];
		if ({lvl, 8'd0} > bar) begin
			bar = {lvl, 8'd0};
			bar_mirror[b] = bar;
			if (bar > peak_mirror[b]) begin
				peak_mirror[b] = bar;
				speed_mirror[b] = SPEED_ON_CAPTURE;
				captures++;
			end else begin
				sink_peak(b);
			end
		end else begin
			if (bar != 16'd0) begin
				st = fall_step_q88(bar_sel);
				bar = (bar > st) ? bar - st : 16'd0;
				bar_mirror[b] = bar;
			end
			sink_peak(b);
		end
		r.bar = bar_mirror[b][15:8];
		r.peak = peak_mirror[b][15:8];
		return r;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// every accepted result item is matched against the oldest prediction
	always @(posedge clk) begin : check_results
		meter_reading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (readings_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result, tdata %h", m_tdata));
			end else begin
				want = readings_q.pop_front();
				results_seen++;
				if (m_tdata[6:0] !== want.bin)
					report_mismatch($sformatf("bin_echo %0d, want %0d",
						m_tdata[6:0], want.bin));
				if (m_tdata[14:7] !== want.bar)
					report_mismatch($sformatf("bin %0d bar_level %0d, want %0d",
						want.bin, m_tdata[14:7], want.bar));
				if (m_tdata[22:15] !== want.peak)
					report_mismatch($sformatf("bin %0d peak_level %0d, want %0d",
						want.bin, m_tdata[22:15], want.peak));
			end
		end
	end

	// ---------------------------------------------------------------- drivers

	// present one sample item, hold until taken, then predict its reading
	task automatic send_sample(input logic [6:0] bin, input logic [7:0] lvl);
		while (!stall_free && $urandom_range(0, 99) < 6) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, lvl, bin};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		readings_q.push_back(meter_update(bin, lvl));
		items_sent++;
	endtask

	// drop the input and let every outstanding result drain
	task automatic settle;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (readings_q.size() != 0)
			@(posedge clk);
	endtask

	// register write, only ever issued with the pipe empty
	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [SEL_W-1:0] val);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_BAR_SEL)
			bar_sel = val;
		else if (idx == REG_PEAK_SEL)
			peak_sel = val;
		reg_writes++;
	endtask

	// ---------------------------------------------------------------- tests

	// store is clear after reset: zero samples read back zero at the first, last and a middle bin
	task automatic test_after_reset;
		send_sample(7'd0, 8'd0);
		send_sample(7'd74, 8'd0);
		send_sample(7'd37, 8'd0);
	endtask

	// field extremes, capture, fall, decay, out-of-range bins, same bin back to back
	task automatic test_directed;
		send_sample(7'd5, 8'd255);      // capture at full scale
		send_sample(7'd5, 8'd0);        // bar falls, peak starts to sink
		send_sample(7'd5, 8'd0);
		send_sample(7'd5, 8'd254);      // below the falling bar: keeps falling
		send_sample(7'd5, 8'd255);      // jump back up past the sunk peak: captured again
		send_sample(7'd74, 8'd255);     // top bin
		send_sample(7'd74, 8'd1);
		send_sample(7'd0, 8'd1);        // smallest non-zero level
		send_sample(7'd0, 8'd0);        // bar of 1.0 falls to 0.66 with step 0.34
		send_sample(7'd0, 8'd0);
		send_sample(7'd0, 8'd0);        // bar reaches zero, peak still above it
		send_sample(7'd75, 8'd255);     // first bin past the store
		send_sample(7'd127, 8'd170);    // largest bin index
		send_sample(7'd127, 8'd85);
		send_sample(7'd100, 8'd0);
		send_sample(7'd0, 8'd128);      // rising captures back to back
		send_sample(7'd0, 8'd200);
		send_sample(7'd0, 8'd150);
		send_sample(7'd42, 8'd255);
		send_sample(7'd42, 8'd254);
	endtask

	// every selector value on the bar register, all but 7 on the peak register, plus writes to undecoded indexes
	task automatic test_registers;
		logic [2:0] picks [7];
		picks = '{3'd4, 3'd7, 3'd5, 3'd1, 3'd2, 3'd3, 3'd6};
		for (int i = 0; i < 7; i++) begin
			reg_write(REG_BAR_SEL, picks[i]);
			reg_write(REG_PEAK_SEL, 3'd7 - picks[i]);
			send_sample(7'd10, 8'd255);
			repeat (4) send_sample(7'd10, 8'd0);
			send_sample(7'd11, 8'd3);
		end
		reg_write(REG_SPARE_2, 3'd7);
		reg_write(REG_SPARE_3, 3'd0);
		send_sample(7'd10, 8'd0);
		send_sample(7'd11, 8'd0);
		reg_write(REG_BAR_SEL, 3'd0);
		reg_write(REG_PEAK_SEL, 3'd0);
		send_sample(7'd12, 8'd90);
		send_sample(7'd12, 8'd0);
	endtask

	// phases under random settings; mostly spectrum frames and long decay runs
	task automatic test_random_phases(input int budget);
		int start_count;
		int phase_start;
		int shape;
		int run_len;
		logic [6:0] bin;
		start_count = items_sent;
		while (items_sent - start_count < budget) begin
			// selectors: forced to an extreme about a third of the time
			if ($urandom_range(0, 2) == 0)
				reg_write(REG_BAR_SEL, $urandom_range(0, 1) ? 3'd0 : 3'd7);
			else
				reg_write(REG_BAR_SEL, 3'($urandom_range(0, 7)));
			if ($urandom_range(0, 2) == 0)
				reg_write(REG_PEAK_SEL, $urandom_range(0, 1) ? 3'd0 : 3'd7);
			else
				reg_write(REG_PEAK_SEL, 3'($urandom_range(0, 7)));
			phase_start = items_sent;
			while (items_sent - phase_start < 130) begin
				shape = $urandom_range(0, 99);
				if (shape < 45) begin
					// one spectrum frame over all bins, half of the levels quiet
					for (int b = 0; b < BINS; b++)
						send_sample(7'(b), $urandom_range(0, 1) ?
							8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255)));
				end else if (shape < 75) begin
					// loud hit then a long quiet tail: peak rides the bar, speed may saturate
					bin = 7'($urandom_range(0, BINS - 1));
					send_sample(bin, 8'($urandom_range(200, 255)));
					run_len = $urandom_range(10, 90);
					repeat (run_len) send_sample(bin, 8'($urandom_range(0, 2)));
				end else if (shape < 90) begin
					// noise over the whole field, out-of-range bins included
					repeat (8) send_sample(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
				end else begin
					// same bin back to back
					bin = 7'($urandom_range(0, BINS - 1));
					run_len = $urandom_range(4, 10);
					repeat (run_len) send_sample(bin, 8'($urandom_range(0, 255)));
				end
			end
		end
	endtask

	// full-rate stretch: no idle cycles on either side
	task automatic test_back_to_back;
		logic [6:0] bin;
		settle();
		stall_free = 1'b1;
		repeat (2) begin
			for (int b = 0; b < BINS; b++)
				send_sample(7'(b), 8'($urandom_range(0, 255)));
		end
		bin = 7'($urandom_range(0, BINS - 1));
		for (int i = 0; i < 30; i++)
			send_sample(bin, (i % 2 == 0) ? 8'd255 : 8'($urandom_range(0, 40)));
		settle();
		stall_free = 1'b0;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin : run_tests
		int spins;
		bar_sel = 3'd0;
		peak_sel = 3'd0;
		for (int b = 0; b < BINS; b++) begin
			bar_mirror[b] = '0;
			peak_mirror[b] = '0;
			speed_mirror[b] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_directed();
		test_registers();
		test_back_to_back();
		test_random_phases(1300);

		// drain, then keep clocking to catch stray results
		s_tvalid <= 1'b0;
		spins = 0;
		while (readings_q.size() != 0 && spins < 20000) begin
			@(posedge clk);
			spins++;
		end
		if (readings_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", readings_q.size()));
		repeat (8) @(posedge clk);

		$display("covered %0d items (%0d to bins past the store), %0d results, %0d register writes",
			items_sent, far_bins, results_seen, reg_writes);
		$display("peak captures %0d, speed saturations %0d, mismatches %0d",
			captures, saturations, mismatches);
		if (mismatches == 0)
			$display("PASS spectrum_bar_peak_falloff_unit");
		else
			$display("FAIL spectrum_bar_peak_falloff_unit");
		$finish;
	end

endmodule

`default_nettype wire
